[hw/rtl/fpfa_pkg.sv]
// Package for the fixed partition fit allocator.
// Holds the function and policy codes and the command type shared by the front and back.
// Depends on nothing.
`timescale 1ns / 1ps

package fpfa_pkg;

	// Function codes of an input beat.
	localparam logic [1:0] FUNC_LOAD     = 2'd0;
	localparam logic [1:0] FUNC_REQUEST  = 2'd1;
	localparam logic [1:0] FUNC_FREE_ALL = 2'd2;
	localparam logic [1:0] FUNC_CLEAR    = 2'd3;

	// Fit policy codes; the unused code behaves as first fit.
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// Width of the size fields on the channels.
	localparam int unsigned PORT_SIZE_W = 16;
	// Width of the reported hole index.
	localparam int unsigned PORT_IDX_W  = 4;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_REQUEST,
		OP_FREE_ALL,
		OP_CLEAR
	} op_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		op_t                    op;
		logic [PORT_SIZE_W-1:0] size;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_RESULT
	} back_state_t;

endpackage

[hw/rtl/fpfa_if.sv]
// Channel interfaces of the fixed partition fit allocator.
// Carries valid, ready and the payload of the item and result channels.
// Depends on nothing.
`timescale 1ns / 1ps

interface fpfa_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] hole_size_in;
	logic [15:0] request_size;

	modport source (output valid, output func, output hole_size_in, output request_size,
		input ready);
	modport sink (input valid, input func, input hole_size_in, input request_size,
		output ready);
endinterface

interface fpfa_result_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [3:0]  hole_index;
	logic [15:0] hole_size_out;

	modport source (output valid, output granted, output hole_index, output hole_size_out,
		input ready);
	modport sink (input valid, input granted, input hole_index, input hole_size_out,
		output ready);
endinterface

[hw/rtl/fpfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module fpfa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/fpfa_front.sv]
// Front of the allocator: accepts item beats, decodes the function code and
// queues the classified commands in a two-entry queue for the back.
// Depends on fpfa_pkg and fpfa_if.
`timescale 1ns / 1ps

module fpfa_front (
	input  logic            clk,
	input  logic            arst_n,
	fpfa_item_if.sink       item,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output fpfa_pkg::cmd_t  cmd
);

	fpfa_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	fpfa_pkg::cmd_t decoded;
	logic           push;
	logic           pop;

	// Classify the incoming beat and keep only the size that its function uses.
	always_comb begin
		decoded.size = item.request_size;
		unique case (item.func)
			fpfa_pkg::FUNC_LOAD: begin
				decoded.op   = fpfa_pkg::OP_LOAD;
				decoded.size = item.hole_size_in;
			end
			fpfa_pkg::FUNC_REQUEST:  decoded.op = fpfa_pkg::OP_REQUEST;
			fpfa_pkg::FUNC_FREE_ALL: decoded.op = fpfa_pkg::OP_FREE_ALL;
			default:                 decoded.op = fpfa_pkg::OP_CLEAR;
		endcase
	end

	assign item.ready = (fill_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd_valid  = (fill_q != 2'd0);
	assign pop        = cmd_valid && cmd_ready;
	assign cmd        = entry_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/fpfa_back.sv]
// Back of the allocator: holds the hole table, runs the fit scan over the stored
// holes one entry a cycle and drives the result register.
// Depends on fpfa_pkg, fpfa_if and fpfa_ram.
`timescale 1ns / 1ps

module fpfa_back #(
	parameter int unsigned MAX_HOLES = 16,
	parameter int unsigned SIZE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  fpfa_pkg::cmd_t  cmd,
	fpfa_result_if.source   result
);

	localparam int unsigned IDX_W  = $clog2(MAX_HOLES);
	localparam int unsigned CNT_W  = $clog2(MAX_HOLES + 1);
	localparam int unsigned CMP_W  = (SIZE_BITS > fpfa_pkg::PORT_SIZE_W) ?
		SIZE_BITS : fpfa_pkg::PORT_SIZE_W;
	localparam int unsigned IDXX_W = (IDX_W > fpfa_pkg::PORT_IDX_W) ?
		IDX_W : fpfa_pkg::PORT_IDX_W;

	fpfa_pkg::back_state_t state_q;
	fpfa_pkg::back_state_t state_d;

	logic [1:0]           policy_q;
	logic [CNT_W-1:0]     count_q;
	logic [MAX_HOLES-1:0] free_q;
	logic [CMP_W-1:0]     want_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [CMP_W-1:0]     pick_size_q;

	logic                 res_valid_q;
	logic                 granted_q;
	logic [3:0]           index_q;
	logic [15:0]          size_out_q;

	logic                 ram_we;
	logic [SIZE_BITS-1:0] ram_rdata;
	logic [CMP_W-1:0]     load_ext;
	logic [CMP_W-1:0]     entry_size;
	logic                 issue;
	logic                 scan_done;
	logic                 fits;
	logic                 better;
	logic                 take_cmd;
	logic                 out_free;
	logic [IDXX_W-1:0]    pick_ext;

	assign load_ext   = CMP_W'(cmd.size);
	assign entry_size = CMP_W'(ram_rdata);
	assign pick_ext   = IDXX_W'(pick_q);

	assign cmd_ready = (state_q == fpfa_pkg::BK_IDLE);
	assign take_cmd  = cmd_valid && cmd_ready;
	assign ram_we    = take_cmd && (cmd.op == fpfa_pkg::OP_LOAD) &&
		(count_q < CNT_W'(MAX_HOLES));
	assign issue     = (state_q == fpfa_pkg::BK_SCAN) && (rd_idx_q < count_q);
	assign scan_done = (state_q == fpfa_pkg::BK_SCAN) && !issue && !rd_vld_s1;
	assign out_free  = !res_valid_q || result.ready;

	// Hole sizes; the write address is the next free slot, the read address the scan index.
	fpfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_HOLES)
	) u_sizes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (load_ext[SIZE_BITS-1:0]),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// A returned entry fits if it is free and at least the request; the policy
	// decides whether it replaces the current pick. Strict compares keep the
	// lowest index on ties.
	always_comb begin
		fits   = rd_vld_s1 && free_q[idx_s1] && (entry_size >= want_q);
		better = !found_q ||
			((policy_q == fpfa_pkg::POL_BEST)  && (entry_size < pick_size_q)) ||
			((policy_q == fpfa_pkg::POL_WORST) && (entry_size > pick_size_q));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpfa_pkg::BK_IDLE: begin
				if (take_cmd && (cmd.op == fpfa_pkg::OP_REQUEST)) begin
					state_d = fpfa_pkg::BK_SCAN;
				end
			end
			fpfa_pkg::BK_SCAN: begin
				if (scan_done) begin
					state_d = fpfa_pkg::BK_RESULT;
				end
			end
			fpfa_pkg::BK_RESULT: begin
				if (out_free) begin
					state_d = fpfa_pkg::BK_IDLE;
				end
			end
			default: state_d = fpfa_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpfa_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Policy register, hole count, free marks and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= fpfa_pkg::POL_FIRST;
			count_q   <= '0;
			free_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_data;
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (fits && better) begin
				found_q <= 1'b1;
			end
			if (take_cmd) begin
				case (cmd.op)
					fpfa_pkg::OP_LOAD: begin
						if (ram_we) begin
							free_q[count_q[IDX_W-1:0]] <= 1'b1;
							count_q <= count_q + CNT_W'(1);
						end
					end
					fpfa_pkg::OP_REQUEST: begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
					end
					fpfa_pkg::OP_FREE_ALL: begin
						for (int i = 0; i < MAX_HOLES; i++) begin
							if (CNT_W'(i) < count_q) begin
								free_q[i] <= 1'b1;
							end
						end
					end
					default: begin
						count_q <= '0;
						free_q  <= '0;
					end
				endcase
			end
			if ((state_q == fpfa_pkg::BK_RESULT) && out_free && found_q) begin
				free_q[pick_q] <= 1'b0;
			end
		end
	end

	// Scan datapath: returned index, requested size and current pick.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (take_cmd) begin
			want_q <= load_ext;
		end
		if (fits && better) begin
			pick_q      <= idx_s1;
			pick_size_q <= entry_size;
		end
	end

	// Result register; a failed request reports zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == fpfa_pkg::BK_RESULT) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == fpfa_pkg::BK_RESULT) && out_free) begin
			granted_q  <= found_q;
			index_q    <= found_q ? pick_ext[3:0] : 4'd0;
			size_out_q <= found_q ? pick_size_q[15:0] : 16'd0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.granted       = granted_q;
	assign result.hole_index    = index_q;
	assign result.hole_size_out = size_out_q;

endmodule

[hw/rtl/fixed_partition_fit_allocator.sv]
// Top level of the fixed partition fit allocator.
// Joins the front, the back and the one-register configuration port.
// Depends on fpfa_pkg, fpfa_if, fpfa_front and fpfa_back.
//
// Use:
//   item   - input beats: func selects load hole, allocation request, free all
//            or clear table; hole_size_in and request_size give the sizes.
//   result - one beat for each allocation request: granted, hole_index and
//            hole_size_out; loads, free-all and clear give no result beat.
//   cfg_we / cfg_data - write the fit policy (first, best or worst fit).
// Timing:
//   Load, free-all and clear are done in the back while it stays idle. A request
//   scans the stored holes one entry a cycle through the registered read port of
//   the size memory, then moves its pick to the output register; the back takes
//   no new command until that result has been written to the output register.
//   A two-entry command queue sits between front and back, so beats are taken
//   while the back scans. A stalled result holds in the output register; the
//   next request waits at the end of its scan until that beat is taken.
// Reset: clears the policy to first fit, empties the table and the queue.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator #(
	parameter int unsigned MAX_HOLES = 16,
	parameter int unsigned SIZE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	fpfa_item_if.sink   item,
	fpfa_result_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data
);

	logic           cmd_valid;
	logic           cmd_ready;
	fpfa_pkg::cmd_t cmd;

	fpfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fpfa_back #(
		.MAX_HOLES (MAX_HOLES),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.result    (result)
	);

endmodule

[hw/rtl/fpfa_checker.sv]
// Port checker for the fixed partition fit allocator, bound to the top level.
// Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  in_func,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_granted,
	input logic [3:0]  out_index,
	input logic [15:0] out_size
);

	logic [2:0] pend_q;
	logic       req_beat;
	logic       res_beat;

	assign req_beat = in_valid && in_ready && (in_func == fpfa_pkg::FUNC_REQUEST);
	assign res_beat = out_valid && out_ready;

	// Requests taken whose result beat has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_beat && !res_beat) begin
			pend_q <= pend_q + 3'd1;
		end else if (res_beat && !req_beat) begin
			pend_q <= pend_q - 3'd1;
		end
	end

	// A stalled result beat keeps its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_granted) &&
		$stable(out_index) && $stable(out_size))
		else $error("result beat changed while stalled");

	// A refused request reports zeros.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_granted |-> out_index == 4'd0 && out_size == 16'd0)
		else $error("refused request with non-zero index or size");

	// Every result beat answers an earlier request.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result beat without an outstanding request");

	// Queue, back and output register hold at most four requests.
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many outstanding requests");

endmodule

bind fixed_partition_fit_allocator fpfa_port_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_func     (item.func),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_granted (result.granted),
	.out_index   (result.hole_index),
	.out_size    (result.hole_size_out)
);

[tb/sv/fpfa_checker.sv]
// Checker for the fixed partition fit allocator: watches the item, result and
// configuration ports, predicts each grant and compares it with the result beats.
// Depends on fpfa_pkg.
`timescale 1ns / 1ps

module fpfa_checker
	import fpfa_pkg::*;
#(
	parameter int unsigned MAX_HOLES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [1:0]  item_func,
	input  logic [15:0] item_hole_size,
	input  logic [15:0] item_request_size,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        result_granted,
	input  logic [3:0]  result_hole_index,
	input  logic [15:0] result_hole_size,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,
	output int unsigned pending,
	output int unsigned fail_count
);

	typedef struct packed {
		logic        granted;
		logic [3:0]  index;
		logic [15:0] size;
	} grant_t;

	// Shadow copy of the partition table and the policy register.
	logic [15:0] part_size [MAX_HOLES];
	bit          part_free [MAX_HOLES];
	int unsigned part_count;
	logic [1:0]  policy;

	// Grants still owed by the block, oldest first.
	grant_t grant_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Prints one line for a mismatch and counts it.
	task automatic report(input string msg);
		$display("checker: %s", msg);
		fail_count++;
	endtask

	// Applies one input beat to the shadow table; returns 1 when it owes a grant.
	function automatic bit predict_grant(input logic [1:0] func, input logic [15:0] load_size,
		input logic [15:0] want, output grant_t g);
		int  i;
		int  pick;
		bit  found;
		found = 0;
		pick  = 0;
		g     = '0;
		case (op_t'(func))
			OP_LOAD: begin
				// A full table ignores further loads.
				if (part_count < MAX_HOLES) begin
					part_size[part_count] = load_size;
					part_free[part_count] = 1'b1;
					part_count++;
				end
				return 1'b0;
			end
			OP_FREE_ALL: begin
				for (i = 0; i < part_count; i++)
					part_free[i] = 1'b1;
				return 1'b0;
			end
			OP_CLEAR: begin
				part_count = 0;
				for (i = 0; i < MAX_HOLES; i++)
					part_free[i] = 1'b0;
				return 1'b0;
			end
			default: begin
				// Scan every loaded hole; ties keep the lowest load index, and the
				// unused policy code behaves as first fit.
				for (i = 0; i < part_count; i++) begin
					if (part_free[i] && part_size[i] >= want) begin
						if (!found) begin
							found = 1'b1;
							pick  = i;
						end else if (policy == POL_BEST && part_size[i] < part_size[pick]) begin
							pick = i;
						end else if (policy == POL_WORST && part_size[i] > part_size[pick]) begin
							pick = i;
						end
					end
				end
				if (found) begin
					part_free[pick] = 1'b0;
					g.granted = 1'b1;
					g.index   = pick[3:0];
					g.size    = part_size[pick];
				end
				return 1'b1;
			end
		endcase
	endfunction

	// Compare result beats first, then account for the item beat of the same edge.
	always @(posedge clk or negedge arst_n) begin : watch
		grant_t want_g;
		grant_t fresh;
		int     i;
		if (!arst_n) begin
			part_count = 0;
			for (i = 0; i < MAX_HOLES; i++) begin
				part_free[i] = 1'b0;
				part_size[i] = '0;
			end
			policy = POL_FIRST;
			grant_q.delete();
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (grant_q.size() == 0) begin
					report($sformatf("result beat with nothing expected at %0t", $realtime));
				end else begin
					want_g = grant_q.pop_front();
					if (result_granted !== want_g.granted)
						report($sformatf("granted %0b, expected %0b at %0t",
							result_granted, want_g.granted, $realtime));
					if (result_hole_index !== want_g.index)
						report($sformatf("hole_index %0d, expected %0d at %0t",
							result_hole_index, want_g.index, $realtime));
					if (result_hole_size !== want_g.size)
						report($sformatf("hole_size_out %0d, expected %0d at %0t",
							result_hole_size, want_g.size, $realtime));
				end
			end
			if (item_valid && item_ready) begin
				if (predict_grant(item_func, item_hole_size, item_request_size, fresh))
					grant_q.push_back(fresh);
			end
			if (cfg_we)
				policy = cfg_data;
			pending <= grant_q.size();
		end
	end

endmodule

[tb/sv/tb_fixed_partition_fit_allocator.sv]
// Testbench top for the fixed partition fit allocator: clock, reset, item and
// result traffic, policy writes and the verdict.
// Depends on fpfa_pkg, fpfa_if, fixed_partition_fit_allocator and fpfa_checker.
`timescale 1ns / 1ps

module tb_fixed_partition_fit_allocator;
	import fpfa_pkg::*;

	localparam int unsigned MAX_HOLES    = 16;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned LONG_HOLD    = 200;
	localparam int unsigned SETTLE       = MAX_HOLES + 8;
	localparam logic [1:0]  POL_UNUSED   = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_data;
	int unsigned pending;
	int unsigned fail_count;
	int unsigned offered;
	bit          quiet;
	bit          hold_req;

	fpfa_item_if   item ();
	fpfa_result_if result ();

	fixed_partition_fit_allocator #(
		.MAX_HOLES(MAX_HOLES),
		.SIZE_BITS(16)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	fpfa_checker #(
		.MAX_HOLES(MAX_HOLES)
	) u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item.valid),
		.item_ready       (item.ready),
		.item_func        (item.func),
		.item_hole_size   (item.hole_size_in),
		.item_request_size(item.request_size),
		.result_valid     (result.valid),
		.result_ready     (result.ready),
		.result_granted   (result.granted),
		.result_hole_index(result.hole_index),
		.result_hole_size (result.hole_size_out),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.pending          (pending),
		.fail_count       (fail_count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	// Result side: random stall bursts, calm stretches and one long hold-off.
	initial begin : receiver
		int unsigned calm;
		calm = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				result.ready <= 1'b1;
			end else if (!quiet && calm == 0 && $urandom_range(0, 5) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 49) == 0)
					calm = $urandom_range(20, 120);
			end
		end
	end

	// Offers one beat, sometimes after an idle burst, and waits until it is taken.
	// Valid stays high afterwards so back-to-back beats need no second assignment.
	task automatic offer(input logic [1:0] func, input logic [15:0] hole_size,
		input logic [15:0] want);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item.valid        <= 1'b1;
		item.func         <= func;
		item.hole_size_in <= hole_size;
		item.request_size <= want;
		do @(posedge clk); while (!item.ready);
		offered++;
	endtask

	// Stops offering and waits until every grant has come back and the block is idle.
	task automatic drain();
		item.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_policy(input logic [1:0] pol);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= pol;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// One allocation episode: clear, load a table, then mostly requests that fit
	// or nearly fit the loaded holes, with some free-all and noise beats.
	task automatic run_episode();
		logic [15:0] loaded [MAX_HOLES];
		logic [15:0] sz;
		logic [15:0] base;
		int          n;
		int          m;
		int          j;
		int          kept;
		int          style;
		int          r;
		if ($urandom_range(0, 9) != 0)
			offer(FUNC_CLEAR, 16'($urandom), 16'($urandom));
		else
			offer(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
		// Now and then overfill the table so the extra loads are dropped.
		if ($urandom_range(0, 5) == 0)
			n = $urandom_range(MAX_HOLES, MAX_HOLES + 3);
		else
			n = $urandom_range(1, MAX_HOLES);
		kept  = (n < MAX_HOLES) ? n : MAX_HOLES;
		style = $urandom_range(0, 2);
		for (j = 0; j < n; j++) begin
			case (style)
				0: sz = 16'($urandom);
				1: begin
					// Few distinct sizes, so best and worst fit meet ties.
					case ($urandom_range(0, 3))
						0: sz = 16'd8;
						1: sz = 16'd64;
						2: sz = 16'd512;
						default: sz = 16'hFFFF;
					endcase
				end
				default: sz = 16'($urandom_range(0, 40));
			endcase
			if (j < MAX_HOLES)
				loaded[j] = sz;
			offer(FUNC_LOAD, sz, 16'($urandom));
		end
		m = $urandom_range(n / 2 + 1, n + 4);
		for (j = 0; j < m; j++) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				offer(FUNC_FREE_ALL, 16'($urandom), 16'($urandom));
			end else if (r == 1) begin
				offer(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
			end else begin
				case ($urandom_range(0, 4))
					0: sz = 16'($urandom);
					1: sz = 16'd0;
					default: begin
						// Exactly, just above or just below a loaded size.
						base = loaded[$urandom_range(0, kept - 1)];
						case ($urandom_range(0, 2))
							0: sz = base;
							1: sz = (base != 16'hFFFF) ? base + 16'd1 : base;
							default: sz = (base != 16'd0) ? base - 16'd1 : base;
						endcase
					end
				endcase
				offer(FUNC_REQUEST, 16'($urandom), sz);
			end
		end
	endtask

	// Reset, directed cases, random phases under each policy, then the verdict.
	initial begin : stimulus
		logic [1:0]  phase_policy [PHASES];
		int unsigned target;
		int          p;
		phase_policy = '{POL_BEST, POL_UNUSED, POL_WORST, POL_FIRST,
			POL_BEST, POL_WORST, POL_UNUSED, POL_FIRST};
		offered           = 0;
		quiet             = 1'b0;
		hold_req          = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_data          = POL_FIRST;
		item.valid        = 1'b0;
		item.func         = FUNC_LOAD;
		item.hole_size_in = '0;
		item.request_size = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First fit: empty table, extreme sizes, zero and full-range requests.
		write_policy(POL_FIRST);
		offer(FUNC_REQUEST, 16'hFFFF, 16'd0);
		offer(FUNC_LOAD, 16'h0000, 16'hFFFF);
		offer(FUNC_LOAD, 16'hFFFF, 16'h0000);
		offer(FUNC_LOAD, 16'd100, 16'd0);
		offer(FUNC_LOAD, 16'd100, 16'd0);
		offer(FUNC_LOAD, 16'd50, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'hFFFF);
		offer(FUNC_REQUEST, 16'd0, 16'd60);
		offer(FUNC_REQUEST, 16'd0, 16'd60);
		offer(FUNC_REQUEST, 16'd0, 16'd60);
		offer(FUNC_FREE_ALL, 16'd0, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'd51);

		// Best fit: the two equal holes go lowest index first.
		write_policy(POL_BEST);
		offer(FUNC_FREE_ALL, 16'd0, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'd60);
		offer(FUNC_REQUEST, 16'd0, 16'd60);
		offer(FUNC_REQUEST, 16'd0, 16'd1);

		// Worst fit, then a cleared table that grants nothing.
		write_policy(POL_WORST);
		offer(FUNC_FREE_ALL, 16'd0, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'd0);
		offer(FUNC_REQUEST, 16'd0, 16'd0);
		offer(FUNC_CLEAR, 16'hFFFF, 16'hFFFF);
		offer(FUNC_REQUEST, 16'd0, 16'd0);

		// Random phases; the second starts with a long result hold-off and the
		// last one runs without idling on either side.
		offered = 0;
		for (p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				quiet = 1'b1;
			write_policy(phase_policy[p]);
			if (p == 1)
				hold_req = 1'b1;
			target = (RANDOM_ITEMS * (p + 1)) / PHASES;
			while (offered < target)
				run_episode();
		end

		drain();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
